### hdl/assert_macros.svh
// Assertion helper macros for the deque block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property prop must hold at every rising edge outside reset.
`define ASSERT_AT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition cond must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/deq_pkg.sv
// Shared types and constants of the double-ended queue.
// No dependencies; imported by every module of the block.
package deq_pkg;

    localparam int DEQ_CAPACITY   = 16;
    localparam int DEQ_WORD_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REVERSE    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] push_word;
    } req_t;

    typedef struct packed {
        logic [31:0] front_word;
        logic [31:0] back_word;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic        is_full;
        logic        op_error;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic exec;   // update pointers, count, store
        logic read;   // fetch end words
    } dp_cmd_t;

endpackage

### hdl/deq_ctrl.sv
// Sequencer of the double-ended queue: one request at a time.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output deq_pkg::dp_cmd_t cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        rsp_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/deq_datapath.sv
// Ring store, head pointer, count and direction flag of the deque.
// Depends on deq_pkg; driven by deq_ctrl commands.
module deq_datapath #(
    parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
    parameter int WORD_WIDTH = deq_pkg::DEQ_WORD_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  deq_pkg::dp_cmd_t cmd,
    input  deq_pkg::req_t    req,
    output deq_pkg::rsp_t    rsp
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [WORD_WIDTH-1:0] mem [CAPACITY];

    logic [2:0]            op_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  rev_reg, rev_next;
    logic                  err_reg, err_next;
    logic [WORD_WIDTH-1:0] lo_reg, hi_reg;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  full, empty, to_front, low_side;
    logic [63:0]           push_wide, lo_wide, hi_wide;
    logic [15:0]           count_wide;
    logic [CNT_W-1:0]      last_pos;

    // physical slot of ring position pos, pos below CAPACITY
    function automatic logic [PTR_W-1:0] slot_at(logic [PTR_W-1:0] head,
                                                  logic [PTR_W-1:0] pos);
        logic [PTR_W:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (PTR_W + 1)'(CAPACITY))
        begin
            s = s - (PTR_W + 1)'(CAPACITY);
        end
        return s[PTR_W-1:0];
    endfunction

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign to_front = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_POP_FRONT);
    assign low_side = (to_front != rev_reg);
    assign last_pos = count_reg - CNT_W'(1);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = slot_at(head_reg, count_reg[PTR_W-1:0]);
        case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (low_side)
                    begin
                        head_next = (head_reg == '0) ? PTR_W'(CAPACITY - 1)
                                                     : head_reg - PTR_W'(1);
                        wr_addr   = head_next;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (empty)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (low_side)
                    begin
                        head_next = slot_at(head_reg, PTR_W'(1));
                    end
                end
            end
            OP_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign push_wide = 64'(req.push_word);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.operation;
            word_reg <= push_wide[WORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            err_reg   <= err_next;
        end
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= word_reg;
        end
        if (cmd.read)
        begin
            lo_reg <= mem[head_reg];
            hi_reg <= mem[slot_at(head_reg, last_pos[PTR_W-1:0])];
        end
    end

    assign lo_wide    = empty ? 64'd0 : 64'(lo_reg);
    assign hi_wide    = empty ? 64'd0 : 64'(hi_reg);
    assign count_wide = 16'(count_reg);

    always_comb
    begin
        rsp.front_word  = rev_reg ? hi_wide[31:0] : lo_wide[31:0];
        rsp.back_word   = rev_reg ? lo_wide[31:0] : hi_wide[31:0];
        rsp.entry_count = count_wide[4:0];
        rsp.is_empty    = empty;
        rsp.is_full     = full;
        rsp.op_error    = err_reg;
    end

endmodule

### hdl/double_ended_queue.sv
// Bounded double-ended queue of data words: ring store with head pointer,
// count and direction flag. Each request carries one operation (query, push
// front, push back, pop front, pop back, reverse) and yields exactly one
// response with the front and back words, the count and the empty, full and
// error flags. A refused push (full) or pop (empty) leaves the queue as it
// was and raises op_error; unused operation codes act as a query. Requests
// are handled one at a time by a four-state sequencer: accept, execute
// (pointer, count and store update), read of both end words through the
// store's registered read ports, then the response transfer. The response
// is offered after the execute and read states, and the next request is
// accepted only once that response has been taken, so requests never
// overlap. Depends on deq_pkg, deq_ctrl, deq_datapath and assert_macros.svh.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
    parameter int WORD_WIDTH = deq_pkg::DEQ_WORD_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  deq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output deq_pkg::rsp_t rsp
);
    import deq_pkg::*;

    dp_cmd_t cmd;

    // sequencer: owns both handshakes
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // datapath: response payload is held in registers, stable while stalled
    deq_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // a request transfer and a pending response never coexist
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, req_valid && !req_stall && rsp_valid, "request taken while response pending")
    // response is offered once the execute and read states follow the request transfer
    `ASSERT_AT_CLK(a_rsp_latency, clk, rst_n, (req_valid && !req_stall) |-> ##3 rsp_valid, "response not offered in time")
    // one response per request: after its transfer the channel falls idle
    `ASSERT_AT_CLK(a_single_rsp, clk, rst_n, (rsp_valid && !rsp_stall) |=> !rsp_valid, "response repeated")
    // the queue cannot report empty and full together
    `ASSERT_NEVER(a_flags, clk, rst_n, rsp_valid && rsp.is_empty && rsp.is_full, "empty and full both set")

endmodule
